// ===== rtl/efrs_pkg.sv =====
// Shared types, constants and register indexes for the earliest-free room scheduler.
package efrs_pkg;

  localparam int MAX_ROOMS_DEF = 64;
  localparam int TIME_BITS_DEF = 16;

  localparam logic REG_ROOM_COUNT = 1'b0;
  localparam logic REG_DAY_LENGTH = 1'b1;

  typedef struct packed {
    logic [15:0] duration;
    logic        last_of_set;
  } lecture_t;

  typedef struct packed {
    logic [5:0]  room;
    logic [15:0] start_time;
    logic        fits;
    logic        schedule_ok;
  } slot_t;

  typedef struct packed {
    logic [6:0]  room_count;
    logic [15:0] day_length;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

// ===== rtl/efrs_core.sv =====
// Finish-time memory, minimum scan and placement sequencer.
module efrs_core import efrs_pkg::*; #(
  parameter int MAX_ROOMS = MAX_ROOMS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     lecture_valid,
  output logic     lecture_ready,
  input  lecture_t lecture,
  input  logic     out_free,
  output logic     done,
  output slot_t    result
);

  localparam int AW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int CW = ($clog2(MAX_ROOMS + 1) > 7) ? $clog2(MAX_ROOMS + 1) : 7;
  localparam int SW = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;

  logic [TIME_BITS-1:0] finish_mem [MAX_ROOMS];
  logic [TIME_BITS-1:0] rdata;

  state_t               state;
  state_t               state_next;
  lecture_t             item;
  logic [AW-1:0]        idx;
  logic                 issued;
  logic                 pend;
  logic [AW-1:0]        pidx;
  logic [AW-1:0]        best_idx;
  logic [TIME_BITS-1:0] best_val;
  logic                 failed;
  logic                 failed_next;

  logic [CW-1:0]        rc_w;
  logic [CW-1:0]        cnt;
  logic [AW-1:0]        last_idx;
  logic [SW-1:0]        sum;
  logic                 fit;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [TIME_BITS-1:0] wr_data;
  logic                 scan_end;

  always_comb begin
    rc_w = CW'(cfg.room_count);
    if (rc_w == '0) begin
      cnt = CW'(1);
    end else if (rc_w > CW'(MAX_ROOMS)) begin
      cnt = CW'(MAX_ROOMS);
    end else begin
      cnt = rc_w;
    end
    last_idx = AW'(cnt - CW'(1));
  end

  assign sum         = SW'(best_val) + SW'(item.duration);
  assign fit         = sum <= SW'(cfg.day_length);
  assign failed_next = failed | ~fit;
  assign scan_end    = pend && (pidx == last_idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      finish_mem[wr_addr] <= wr_data;
    end
    rdata <= finish_mem[idx];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (idx == AW'(MAX_ROOMS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (lecture_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_next = item.last_of_set ? ST_CLEAR : ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    lecture_ready = 1'b0;
    done          = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = idx;
    wr_data       = '0;
    case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_IDLE: begin
        lecture_ready = 1'b1;
      end
      ST_SCAN: begin
      end
      ST_UPDATE: begin
        done    = out_free;
        wr_en   = out_free & fit;
        wr_addr = best_idx;
        wr_data = sum[TIME_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  assign result.room        = 6'(best_idx);
  assign result.start_time  = 16'(best_val);
  assign result.fits        = fit;
  assign result.schedule_ok = ~failed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      idx    <= '0;
      issued <= 1'b0;
      pend   <= 1'b0;
      failed <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: begin
          idx <= (idx == AW'(MAX_ROOMS - 1)) ? '0 : idx + AW'(1);
        end
        ST_IDLE: begin
          idx    <= '0;
          issued <= 1'b0;
          pend   <= 1'b0;
        end
        ST_SCAN: begin
          pend <= ~issued;
          pidx <= idx;
          if (!issued) begin
            if (idx == last_idx) begin
              issued <= 1'b1;
            end else begin
              idx <= idx + AW'(1);
            end
          end
          // strict less-than keeps the lowest room on ties
          if (pend && (pidx == '0 || rdata < best_val)) begin
            best_val <= rdata;
            best_idx <= pidx;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            idx    <= '0;
            failed <= item.last_of_set ? 1'b0 : failed_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (lecture_valid && lecture_ready) begin
      item <= lecture;
    end
  end

endmodule

// ===== rtl/earliest_free_room_scheduler.sv =====
// Top level of the earliest-free room scheduler: config registers and result register.
//
// Channels: lecture (valid/ready) carries one duration and a last-of-set mark;
// slot (valid/ready) returns one word per lecture with the room, start time,
// fit flag and set status; cfg (valid/ready, always ready) writes room_count (index 0)
// or day_length (index 1); the user must do so only while the block is idle, which
// the block does not enforce. Each lecture scans the finish-time memory one entry
// per cycle over the rooms in use (room_count, zero taken as one, capped at
// MAX_ROOMS); the slot word is registered once the scan ends and the result
// register is free, and the next lecture is accepted only after that, back in
// idle; the one memory read per cycle sets the scan rate.
// After a lecture marked last, and after reset, a clearing pass zeroes all
// MAX_ROOMS finish times at one entry per cycle before the next lecture is
// taken; the failure flag clears at the same point.
// Reset is synchronous; it sets room_count to 1 and day_length to 65535.
// A stalled slot word holds in its register; the next lecture may be accepted
// and scanned meanwhile, and its result waits until the register frees up.
module earliest_free_room_scheduler import efrs_pkg::*; #(
  parameter int MAX_ROOMS = MAX_ROOMS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        lecture_valid,
  output logic        lecture_ready,
  input  lecture_t    lecture,
  output logic        slot_valid,
  input  logic        slot_ready,
  output slot_t       slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  logic  out_free;
  logic  done;
  slot_t result;

  assign cfg_ready = 1'b1;
  assign out_free  = ~slot_valid | slot_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.room_count <= 7'd1;
      cfg.day_length <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROOM_COUNT: cfg.room_count <= cfg_data[6:0];
        REG_DAY_LENGTH: cfg.day_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (done) begin
      slot_valid <= 1'b1;
    end else if (slot_ready) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      slot <= result;
    end
  end

  efrs_core #(
    .MAX_ROOMS(MAX_ROOMS),
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .lecture_valid(lecture_valid),
    .lecture_ready(lecture_ready),
    .lecture      (lecture),
    .out_free     (out_free),
    .done         (done),
    .result       (result)
  );

endmodule
